>>> design/quadratic_root_solver_top_assert.svh
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// Implication checked on every clock edge, held off during reset.
`define QRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quadratic root solver check failed");

// Next-cycle implication, held off during reset.
`define QRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quadratic root solver check failed");

`endif

>>> design/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;
    localparam int COEF_W    = 16;
    localparam int FRAC      = 16;
    localparam int ROOT_W    = 34;
    localparam int D_W       = 34;  // discriminant, signed
    localparam int RAD_W     = 34;  // radicand shift register
    localparam int SQ_STEPS  = 33;
    localparam int SQ_W      = 33;
    localparam int SQ_REM_W  = 35;
    localparam int NUM_W     = 34;  // numerator magnitude
    localparam int NUM_S_W   = 35;  // signed numerator
    localparam int DEN_W     = 17;  // denominator magnitude
    localparam int DIV_STEPS = 34;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic [1:0]               count;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic [RAD_W-1:0]         rad;
        logic [SQ_W-1:0]          root;
        logic [SQ_REM_W-1:0]      rem;
    } t_sq_data;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } t_div_lane;

    typedef struct packed {
        logic             valid;
        logic [1:0]       count;
        logic             neg1;
        logic             neg2;
        logic [DEN_W-1:0] den;
        t_div_lane        l1;
        t_div_lane        l2;
    } t_div_data;
endpackage

>>> design/quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// Solves a*x^2 + b*x + c = 0 for 16-bit signed coefficients and returns a
// root count (0 none, 1 one, 2 two, 3 infinitely many) and up to two roots
// in signed 34-bit fixed point with 16 fractional bits; absent roots read
// zero. A zero a falls back to the linear root -c/b. The block takes one
// item every cycle unless o_stall is high; it passes through three front
// stages (register, multiplies, discriminant), a row of 33 square-root
// cells (one result bit each), one numerator stage, a row of 34 divider
// cells (one quotient bit per root each) and the output register. The
// whole row advances together, so o_stall is high only while a result sits
// in the output and i_stall holds it there.
module quadratic_root_solver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_coef_quad,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_coef_lin,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_coef_const,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_root_count,
    output logic signed [qrs_pkg::ROOT_W-1:0]   o_root_first,
    output logic signed [qrs_pkg::ROOT_W-1:0]   o_root_second
);
    import qrs_pkg::*;

    `include "quadratic_root_solver_top_assert.svh"

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: input register
    logic                     r_v1;
    logic signed [COEF_W-1:0] r_a1, r_b1, r_c1;
    // stage 2: products
    logic                     r_v2;
    logic signed [COEF_W-1:0] r_a2, r_b2, r_c2;
    logic signed [2*COEF_W-1:0] r_bb, r_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_a1 <= i_coef_quad;
            r_b1 <= i_coef_lin;
            r_c1 <= i_coef_const;
            r_v2 <= r_v1;
            r_a2 <= r_a1;
            r_b2 <= r_b1;
            r_c2 <= r_c1;
            r_bb <= r_b1 * r_b1;
            r_ac <= r_a1 * r_c1;
        end
    end

    // stage 3: discriminant and count, feeds the square-root row
    t_sq_data          sq_link [0:SQ_STEPS];
    logic signed [D_W-1:0] disc;
    t_sq_data          r_sq_in;
    t_sq_data          n_sq_in;

    always_comb begin
        disc          = D_W'(r_bb) - (D_W'(r_ac) <<< 2);
        n_sq_in       = '0;
        n_sq_in.valid = r_v2;
        n_sq_in.a     = r_a2;
        n_sq_in.b     = r_b2;
        n_sq_in.c     = r_c2;
        if (r_a2 == '0) begin
            if (r_b2 == '0) begin
                n_sq_in.count = (r_c2 == '0) ? CNT_INF : CNT_NONE;
            end else begin
                n_sq_in.count = CNT_ONE;
            end
        end else if (disc[D_W-1]) begin
            n_sq_in.count = CNT_NONE;
        end else if (disc == '0) begin
            n_sq_in.count = CNT_ONE;
        end else begin
            n_sq_in.count = CNT_TWO;
            n_sq_in.rad   = RAD_W'(unsigned'(disc));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_in.valid <= 1'b0;
        end else if (en) begin
            r_sq_in <= n_sq_in;
        end
    end

    assign sq_link[0] = r_sq_in;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (sq_link[g]),
            .o_d     (sq_link[g+1])
        );
    end

    // stage 4: signed numerators and denominator, feeds the divider row
    t_sq_data                sq_out;
    logic signed [NUM_S_W-1:0] nb, n1, n2;
    logic signed [DEN_W:0]     den_s;
    t_div_data               n_dv_in;
    t_div_data               r_dv_in;
    t_div_data               dv_link [0:DIV_STEPS];

    always_comb begin
        sq_out = sq_link[SQ_STEPS];
        nb     = -(NUM_S_W'(sq_out.b) <<< FRAC);
        if (sq_out.a == '0) begin
            n1    = -(NUM_S_W'(sq_out.c) <<< FRAC);
            n2    = '0;
            den_s = (DEN_W+1)'(sq_out.b);
        end else begin
            n1    = nb - NUM_S_W'(sq_out.root);
            n2    = nb + NUM_S_W'(sq_out.root);
            den_s = (DEN_W+1)'(sq_out.a) <<< 1;
        end
        n_dv_in        = '0;
        n_dv_in.valid  = sq_out.valid;
        n_dv_in.count  = sq_out.count;
        n_dv_in.neg1   = n1[NUM_S_W-1] ^ den_s[DEN_W];
        n_dv_in.neg2   = n2[NUM_S_W-1] ^ den_s[DEN_W];
        n_dv_in.den    = den_s[DEN_W] ? DEN_W'(-den_s) : DEN_W'(den_s);
        n_dv_in.l1.num = n1[NUM_S_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
        n_dv_in.l2.num = n2[NUM_S_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_in.valid <= 1'b0;
        end else if (en) begin
            r_dv_in <= n_dv_in;
        end
    end

    assign dv_link[0] = r_dv_in;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_dv
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (dv_link[g]),
            .o_d     (dv_link[g+1])
        );
    end

    // output register: sign restore, absent roots forced to zero
    t_div_data              dv_out;
    logic [ROOT_W-1:0]      q1, q2;
    logic                   r_out_valid;
    logic [1:0]             r_count;
    logic [ROOT_W-1:0]      r_root1, r_root2;

    always_comb begin
        dv_out = dv_link[DIV_STEPS];
        q1     = dv_out.neg1 ? ROOT_W'(-dv_out.l1.quo) : ROOT_W'(dv_out.l1.quo);
        q2     = dv_out.neg2 ? ROOT_W'(-dv_out.l2.quo) : ROOT_W'(dv_out.l2.quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_out.valid;
            r_count     <= dv_out.count;
            r_root1     <= (dv_out.count == CNT_ONE || dv_out.count == CNT_TWO) ? q1 : '0;
            r_root2     <= (dv_out.count == CNT_TWO) ? q2 : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_root_count  = r_count;
    assign o_root_first  = signed'(r_root1);
    assign o_root_second = signed'(r_root2);

    `QRS_ASSERT_IMP(a_absent_zero, o_valid && (o_root_count == CNT_NONE || o_root_count == CNT_INF), o_root_first == '0 && o_root_second == '0)
    `QRS_ASSERT_IMP(a_one_second_zero, o_valid && o_root_count == CNT_ONE, o_root_second == '0)
    `QRS_ASSERT_IMP(a_stall_only_when_full, o_stall, o_valid && i_stall)
    `QRS_ASSERT_NXT(a_row_holds, !en, $stable(dv_link[DIV_STEPS]) && $stable(sq_link[SQ_STEPS]))
endmodule

>>> design/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
module qrs_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  qrs_pkg::t_sq_data i_d,
    output qrs_pkg::t_sq_data o_d
);
    import qrs_pkg::*;

    t_sq_data              r_d;
    t_sq_data              n_d;
    logic [SQ_REM_W+1:0]   rem_ext;
    logic [SQ_REM_W+1:0]   trial;
    logic                  ge;

    // one digit of the square root per cell
    always_comb begin
        rem_ext = {i_d.rem, i_d.rad[RAD_W-1 -: 2]};
        trial   = (SQ_REM_W+2)'({i_d.root, 2'b01});
        ge      = rem_ext >= trial;
        n_d     = i_d;
        n_d.rad = {i_d.rad[RAD_W-3:0], 2'b00};
        if (ge) begin
            n_d.rem  = SQ_REM_W'(rem_ext - trial);
            n_d.root = {i_d.root[SQ_W-2:0], 1'b1};
        end else begin
            n_d.rem  = SQ_REM_W'(rem_ext);
            n_d.root = {i_d.root[SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> design/qrs_div_cell.sv
`timescale 1ns / 1ps
module qrs_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  qrs_pkg::t_div_data i_d,
    output qrs_pkg::t_div_data o_d
);
    import qrs_pkg::*;

    t_div_data r_d;
    t_div_data n_d;

    function automatic t_div_lane step(input t_div_lane l, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] rem_ext;
        logic           ge;
        t_div_lane      o;
        rem_ext = {l.rem, l.num[NUM_W-1]};
        ge      = rem_ext >= {1'b0, den};
        o.num   = {l.num[NUM_W-2:0], 1'b0};
        o.quo   = {l.quo[NUM_W-2:0], ge};
        o.rem   = ge ? DEN_W'(rem_ext - {1'b0, den}) : DEN_W'(rem_ext);
        return o;
    endfunction

    // one quotient bit per lane per cell
    always_comb begin
        n_d    = i_d;
        n_d.l1 = step(i_d.l1, i_d.den);
        n_d.l2 = step(i_d.l2, i_d.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
